// File: rtl/core/cau_pkg.sv
package cau_pkg;

  localparam int DW     = 32;      // operand and result word width
  localparam int PW     = 2 * DW;  // exact product width
  localparam int QB     = DW + 1;  // quotient bits produced by the divider
  localparam int LAT    = QB;      // latency of the divide and root pipelines
  localparam int QDEPTH = 2;       // entries in the front-to-back queue
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    FN_ADD  = 3'd0,
    FN_MUL  = 3'd1,
    FN_CONJ = 3'd2,
    FN_MAG  = 3'd3,
    FN_DIV  = 3'd4
  } cau_func_e;

  // Work class decided by the front end.
  typedef enum logic [2:0] {
    CLS_NOP,
    CLS_ADD,
    CLS_MUL,
    CLS_CONJ,
    CLS_MAG,
    CLS_DIV,
    CLS_DZ
  } cau_cls_e;

  typedef struct packed {
    logic [2:0]           func;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 saturated;
    logic                 div_by_zero;
  } cau_out_t;

  typedef struct packed {
    cau_cls_e             cls;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } cau_cmd_t;

endpackage

// File: rtl/core/cau_front.sv
module cau_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  cau_pkg::cau_in_t  req_i,
  input  logic              full_i,
  output logic              push_o,
  output cau_pkg::cau_cmd_t cmd_o
);
  import cau_pkg::*;

  cau_cmd_t cmd_d, cmd_q;
  logic     vld_d, vld_q;
  logic     accept;
  logic     b_zero;

  assign busy_o = vld_q && full_i;
  assign push_o = vld_q && !full_i;
  assign accept = start_i && !busy_o;
  assign cmd_o  = cmd_q;
  assign b_zero = (req_i.b_re == '0) && (req_i.b_im == '0);

  always_comb begin
    cmd_d.a_re = req_i.a_re;
    cmd_d.a_im = req_i.a_im;
    cmd_d.b_re = req_i.b_re;
    cmd_d.b_im = req_i.b_im;
    unique case (cau_func_e'(req_i.func))
      FN_ADD:  cmd_d.cls = CLS_ADD;
      FN_MUL:  cmd_d.cls = CLS_MUL;
      FN_CONJ: cmd_d.cls = CLS_CONJ;
      FN_MAG:  cmd_d.cls = CLS_MAG;
      FN_DIV:  cmd_d.cls = b_zero ? CLS_DZ : CLS_DIV;
      default: cmd_d.cls = CLS_NOP;
    endcase
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// File: rtl/core/cau_queue.sv
module cau_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cau_pkg::cau_cmd_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output cau_pkg::cau_cmd_t data_o
);
  import cau_pkg::*;

  cau_cmd_t       mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   cnt_d, cnt_q;

  assign full_o  = cnt_q == (QAW+1)'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && full_o |-> pop_i)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue read while empty");

endmodule

// File: rtl/core/cau_div.sv
module cau_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic [cau_pkg::PW-1:0] num_i,
  input  logic [cau_pkg::PW-1:0] den_i,
  output logic [cau_pkg::QB-1:0] quo_o,
  output logic                   ovf_o
);
  import cau_pkg::*;

  // Remainder width: holds num << FRAC_BITS and den << QB.
  localparam int RW = PW + QB;

  logic [RW-1:0] x, dw;
  logic          ovf0;
  logic [RW-1:0] rem_q [QB];
  logic [RW-1:0] dsr_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic          ovf_q [QB];

  assign x    = {{(RW-PW){1'b0}}, num_i} << FRAC_BITS;
  assign dw   = {{(RW-PW){1'b0}}, den_i};
  // A quotient wider than QB bits saturates, so only the flag is kept then.
  assign ovf0 = x >= (dw << QB);

  for (genvar k = 0; k < QB; k++) begin : g_step
    localparam int SH = QB - 1 - k;
    logic [RW-1:0] rin, din, trial;
    logic [QB-1:0] qin;
    logic          oin, ge;

    if (k == 0) begin : g_first
      assign rin = x;
      assign din = dw;
      assign qin = '0;
      assign oin = ovf0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = dsr_q[k-1];
      assign qin = quo_q[k-1];
      assign oin = ovf_q[k-1];
    end

    assign trial = din << SH;
    assign ge    = rin >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? rin - trial : rin;
      dsr_q[k] <= din;
      quo_q[k] <= {qin[QB-2:0], ge};
      ovf_q[k] <= oin;
    end
  end

  assign quo_o = quo_q[QB-1];
  assign ovf_o = ovf_q[QB-1];

endmodule

// File: rtl/core/cau_sqrt.sv
module cau_sqrt (
  input  logic                   clk_i,
  input  logic [cau_pkg::PW-1:0] rad_i,
  output logic [cau_pkg::DW-1:0] root_o
);
  import cau_pkg::*;

  localparam int TW = PW + 1;

  logic [TW-1:0] rad0_q;
  logic [TW-1:0] rem_q  [DW];
  logic [DW-1:0] root_q [DW];

  always_ff @(posedge clk_i) begin
    rad0_q <= {1'b0, rad_i};
  end

  // One result bit per stage: test (root + 2^i)^2 - root^2 against the remainder.
  for (genvar k = 0; k < DW; k++) begin : g_step
    localparam int BI = DW - 1 - k;
    logic [TW-1:0] rin, trial;
    logic [DW-1:0] qin;
    logic          ge;

    if (k == 0) begin : g_first
      assign rin = rad0_q;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
    end

    assign trial = ({{(TW-DW){1'b0}}, qin} << (BI + 1)) + (TW'(1) << (2 * BI));
    assign ge    = rin >= trial;

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= ge ? rin - trial : rin;
      root_q[k] <= ge ? (qin | (DW'(1) << BI)) : qin;
    end
  end

  assign root_o = root_q[DW-1];

endmodule

// File: rtl/core/cau_back.sv
module cau_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  cau_pkg::cau_cmd_t head_i,
  output logic              pop_o,
  output logic              strobe_o,
  output cau_pkg::cau_out_t res_o
);
  import cau_pkg::*;

  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXW = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINW = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QB-1:0] HALF = QB'(1) << (DW - 1);

  typedef struct packed {
    logic          hit;
    logic [DW-1:0] val;
  } sat_t;

  typedef struct packed {
    cau_cls_e cls;
    sat_t     re;
    sat_t     im;
    logic     re_neg;
    logic     im_neg;
  } side_t;

  function automatic sat_t sat_fn(input logic signed [SW-1:0] v);
    sat_t r;
    r.hit = 1'b0;
    r.val = v[DW-1:0];
    if (v > MAXV) begin
      r.hit = 1'b1;
      r.val = MAXW;
    end else if (v < MINV) begin
      r.hit = 1'b1;
      r.val = MINW;
    end
    return r;
  endfunction

  function automatic sat_t div_sat(input logic [QB-1:0] q, input logic ovf, input logic neg);
    sat_t          r;
    logic [QB-1:0] nq;
    nq    = ~q + 1'b1;
    r.hit = 1'b0;
    r.val = q[DW-1:0];
    if (neg) begin
      if (ovf || q > HALF) begin
        r.hit = 1'b1;
        r.val = MINW;
      end else begin
        r.val = nq[DW-1:0];
      end
    end else if (ovf || q >= HALF) begin
      r.hit = 1'b1;
      r.val = MAXW;
    end
    return r;
  endfunction

  localparam sat_t SAT_ZERO = '{hit: 1'b0, val: '0};

  // Stage A: products and the simple operations.
  logic signed [DW-1:0] sq0_op, sq1_op;
  sat_t                 sa_re_d, sa_im_d;
  logic                 vld_a_q;
  cau_cls_e             cls_a_q;
  sat_t                 sa_re_q, sa_im_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, sq0_q, sq1_q;

  // Stage B: sums, numerators and the divisor or radicand.
  logic signed [SW-1:0] mul_re, mul_im, n_re, n_im, n_re_abs, n_im_abs;
  side_t                side_b_d, side_b_q;
  logic                 vld_b_q;
  logic [PW-1:0]        nre_mag_q, nim_mag_q, sumsq_q;

  // Long-latency units and the matching delay line.
  logic [QB-1:0]  quo_re, quo_im;
  logic           ovf_re, ovf_im;
  logic [DW-1:0]  root;
  side_t          line_q [LAT];
  logic [LAT-1:0] vld_line_q;
  side_t          tap;
  cau_out_t       res_d, res_q;
  logic           strobe_q;
  sat_t           fin_re, fin_im;

  assign pop_o = head_valid_i;

  assign sq0_op = (head_i.cls == CLS_MAG) ? head_i.a_re : head_i.b_re;
  assign sq1_op = (head_i.cls == CLS_MAG) ? head_i.a_im : head_i.b_im;

  always_comb begin
    sa_re_d = SAT_ZERO;
    sa_im_d = SAT_ZERO;
    case (head_i.cls)
      CLS_ADD: begin
        sa_re_d = sat_fn(SW'(head_i.a_re) + SW'(head_i.b_re));
        sa_im_d = sat_fn(SW'(head_i.a_im) + SW'(head_i.b_im));
      end
      CLS_CONJ: begin
        sa_re_d = sat_fn(SW'(head_i.a_re));
        sa_im_d = sat_fn(-SW'(head_i.a_im));
      end
      default: begin
        sa_re_d = SAT_ZERO;
        sa_im_d = SAT_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cls_a_q <= head_i.cls;
    sa_re_q <= sa_re_d;
    sa_im_q <= sa_im_d;
    p_rr_q  <= $signed(head_i.a_re) * $signed(head_i.b_re);
    p_ii_q  <= $signed(head_i.a_im) * $signed(head_i.b_im);
    p_ri_q  <= $signed(head_i.a_re) * $signed(head_i.b_im);
    p_ir_q  <= $signed(head_i.a_im) * $signed(head_i.b_re);
    sq0_q   <= $signed(sq0_op) * $signed(sq0_op);
    sq1_q   <= $signed(sq1_op) * $signed(sq1_op);
  end

  assign mul_re   = (SW'(p_rr_q) - SW'(p_ii_q)) >>> FRAC_BITS;
  assign mul_im   = (SW'(p_ri_q) + SW'(p_ir_q)) >>> FRAC_BITS;
  assign n_re     = SW'(p_rr_q) + SW'(p_ii_q);
  assign n_im     = SW'(p_ir_q) - SW'(p_ri_q);
  assign n_re_abs = n_re[SW-1] ? -n_re : n_re;
  assign n_im_abs = n_im[SW-1] ? -n_im : n_im;

  always_comb begin
    side_b_d.cls    = cls_a_q;
    side_b_d.re     = sa_re_q;
    side_b_d.im     = sa_im_q;
    side_b_d.re_neg = n_re[SW-1];
    side_b_d.im_neg = n_im[SW-1];
    if (cls_a_q == CLS_MUL) begin
      side_b_d.re = sat_fn(mul_re);
      side_b_d.im = sat_fn(mul_im);
    end
  end

  always_ff @(posedge clk_i) begin
    side_b_q  <= side_b_d;
    nre_mag_q <= n_re_abs[PW-1:0];
    nim_mag_q <= n_im_abs[PW-1:0];
    sumsq_q   <= sq0_q[PW-1:0] + sq1_q[PW-1:0];
  end

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk_i (clk_i),
    .num_i (nre_mag_q),
    .den_i (sumsq_q),
    .quo_o (quo_re),
    .ovf_o (ovf_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk_i (clk_i),
    .num_i (nim_mag_q),
    .den_i (sumsq_q),
    .quo_o (quo_im),
    .ovf_o (ovf_im)
  );

  cau_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sumsq_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    line_q[0] <= side_b_q;
    for (int k = 1; k < LAT; k++) begin
      line_q[k] <= line_q[k-1];
    end
  end

  assign tap = line_q[LAT-1];

  always_comb begin
    fin_re = tap.re;
    fin_im = tap.im;
    case (tap.cls)
      CLS_DIV: begin
        fin_re = div_sat(quo_re, ovf_re, tap.re_neg);
        fin_im = div_sat(quo_im, ovf_im, tap.im_neg);
      end
      CLS_MAG: begin
        fin_re.hit = root[DW-1];
        fin_re.val = root[DW-1] ? MAXW : root;
        fin_im     = SAT_ZERO;
      end
      default: begin
        fin_re = tap.re;
        fin_im = tap.im;
      end
    endcase
    res_d.res_re      = fin_re.val;
    res_d.res_im      = fin_im.val;
    res_d.saturated   = fin_re.hit | fin_im.hit;
    res_d.div_by_zero = tap.cls == CLS_DZ;
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q    <= 1'b0;
      vld_b_q    <= 1'b0;
      vld_line_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      vld_a_q    <= pop_o;
      vld_b_q    <= vld_a_q;
      vld_line_q <= {vld_line_q[LAT-2:0], vld_b_q};
      strobe_q   <= vld_line_q[LAT-1];
    end
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(pop_o, LAT + 3))
    else $error("result without a matching item");
  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && res_o.div_by_zero |->
      res_o.res_re == '0 && res_o.res_im == '0 && !res_o.saturated)
    else $error("zero-divisor result not cleared");

endmodule

// File: rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, multiply, conjugate, magnitude and divide on Q16.16.
// An accepted beat passes the front register, the queue, stages A and B, the quotient
// or root pipeline and the output register before its result strobe rises. Throughput:
// one beat per cycle; the receiver cannot stall and the back end never stalls, so busy
// stays low. The fixed latency is set by the 33-step quotient pipeline and the root pipeline.
// Reset is asynchronous and active low; it empties the queue and all valid stages.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  req_i,
  output logic              strobe_o,
  output cau_pkg::cau_out_t res_o
);
  import cau_pkg::*;

  // Front end: registers the beat and decodes the operation into a work class,
  // spotting a divide by a zero operand early so the back end only zeroes it.
  cau_cmd_t front_cmd;
  logic     front_push;
  logic     queue_full;

  // Queue head seen by the back end.
  cau_cmd_t head_cmd;
  logic     head_valid;
  logic     head_pop;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .req_i   (req_i),
    .full_i  (queue_full),
    .push_o  (front_push),
    .cmd_o   (front_cmd)
  );

  // A two-entry queue decouples the front end from the arithmetic pipeline.
  cau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_cmd),
    .full_o  (queue_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_cmd)
  );

  // Back end: six multipliers, a sum stage, two quotient pipelines and one
  // root pipeline sharing the sum of squares, then saturation and output.
  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_cmd),
    .pop_o        (head_pop),
    .strobe_o     (strobe_o),
    .res_o        (res_o)
  );

endmodule

// File: tb/tb_complex_arithmetic_unit.sv
module tb_complex_arithmetic_unit;
  import cau_pkg::*;

  // Codes 5 to 7 are not assigned to any operation; the unit must answer
  // them with an all-zero beat.
  localparam logic [2:0] FN_SPARE5 = 3'd5;
  localparam logic [2:0] FN_SPARE6 = 3'd6;
  localparam logic [2:0] FN_SPARE7 = 3'd7;

  localparam logic signed [DW-1:0] WMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] WMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE  = 32'sh0001_0000;
  localparam int N_RANDOM   = 1530;
  localparam int DRAIN_WAIT = 60;
  localparam int FRAC       = 16;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  cau_in_t  req_i;
  logic     strobe_o;
  cau_out_t res_o;

  complex_arithmetic_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .strobe_o(strobe_o),
    .res_o   (res_o)
  );

  // Free-running clock with a period of 10 time units.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Expected beats, oldest first, and the bookkeeping of the checker.
  cau_out_t expected_beats[$];
  int       mismatches;
  int       beats_seen;
  int       ops_done[8];
  logic     clip_hit;

  // Directed-row side channel: when set, the beat the driver is offering
  // carries a hand-written expectation instead of a predicted one.
  logic     row_typed;
  cau_out_t row_expect;

  // Clamp a wide signed value into the Q16.16 word and note any clipping.
  function automatic logic [DW-1:0] clamp_word(input logic signed [127:0] v);
    if (v > 128'(WMAX)) begin
      clip_hit = 1'b1;
      return WMAX;
    end
    if (v < 128'(WMIN)) begin
      clip_hit = 1'b1;
      return WMIN;
    end
    return v[DW-1:0];
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Quotient of a Q.2F numerator by a Q.2F divisor, truncated toward zero.
  function automatic logic signed [127:0] scaled_quotient(input logic signed [127:0] num,
                                                          input logic [127:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num < 0 ? 128'(-num) : 128'(num);
    q   = (mag << FRAC) / den;
    return num < 0 ? -$signed(q) : $signed(q);
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t op);
    cau_out_t r;
    logic signed [127:0] ar, ai, br, bi, den;
    ar = op.a_re;
    ai = op.a_im;
    br = op.b_re;
    bi = op.b_im;
    r = '0;
    clip_hit = 1'b0;
    case (op.func)
      FN_ADD: begin
        r.res_re = clamp_word(ar + br);
        r.res_im = clamp_word(ai + bi);
      end
      FN_MUL: begin
        r.res_re = clamp_word((ar * br - ai * bi) >>> FRAC);
        r.res_im = clamp_word((ar * bi + br * ai) >>> FRAC);
      end
      FN_CONJ: begin
        r.res_re = clamp_word(ar);
        r.res_im = clamp_word(-ai);
      end
      FN_MAG: begin
        r.res_re = clamp_word($signed({64'd0, floor_root(64'(ar * ar + ai * ai))}));
      end
      FN_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_by_zero = 1'b1;
        end else begin
          r.res_re = clamp_word(scaled_quotient(ar * br + ai * bi, den));
          r.res_im = clamp_word(scaled_quotient(ai * br - ar * bi, den));
        end
      end
      default: ;
    endcase
    r.saturated = clip_hit;
    return r;
  endfunction

  // Checker and expectation store. Every signal read here changes only at the
  // falling edge or through the unit's own nonblocking updates, so the values
  // seen at the rising edge are the ones the unit itself samples.
  always @(posedge clk_i) begin
    cau_out_t want;
    if (rst_ni && strobe_o) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat re=%h im=%h sat=%b dz=%b",
                   res_o.res_re, res_o.res_im, res_o.saturated, res_o.div_by_zero);
      end else begin
        want = expected_beats.pop_front();
        if (res_o.res_re !== want.res_re || res_o.res_im !== want.res_im ||
            res_o.saturated !== want.saturated ||
            res_o.div_by_zero !== want.div_by_zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: beat %0d exp re=%h im=%h sat=%b dz=%b got re=%h im=%h sat=%b dz=%b",
                     beats_seen, want.res_re, want.res_im, want.saturated, want.div_by_zero,
                     res_o.res_re, res_o.res_im, res_o.saturated, res_o.div_by_zero);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      ops_done[req_i.func]++;
      expected_beats.push_back(row_typed ? row_expect : complex_result(req_i));
    end
  end

  // Offer one beat from the falling edge on and hold it until it is taken.
  task automatic offer_beat(input cau_in_t op, input logic typed, input cau_out_t want);
    logic taken;
    req_i      = op;
    row_typed  = typed;
    row_expect = want;
    start      = 1'b1;
    taken      = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy;
      @(negedge clk_i);
    end
  endtask

  // Sender idling: each check idles with a chance of 27 in a hundred, only while allow is set.
  task automatic maybe_idle(input logic allow);
    while (allow && $urandom_range(99) < 27) begin
      start = 1'b0;
      req_i = {3'($urandom), $urandom, $urandom, $urandom, $urandom};
      @(negedge clk_i);
    end
  endtask

  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return WMAX;
      1:       return WMIN;
      2:       return '0;
      3, 4:    return DW'($signed(20'($urandom)));
      5:       return DW'($signed(26'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_func();
    int roll;
    roll = $urandom_range(99);
    if (roll < 94) return 3'(roll % 5);
    return 3'($urandom_range(FN_SPARE7, FN_SPARE5));
  endfunction

  typedef struct {
    cau_in_t  op;
    logic     typed;
    cau_out_t want;
  } stim_row_t;

  stim_row_t directed[] = '{
    '{'{FN_ADD, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
    '{'{FN_ADD, WMAX, WMIN, ONE, -ONE}, 1'b1, '{WMAX, WMIN, 1'b1, 1'b0}},
    '{'{FN_ADD, WMIN, WMAX, WMIN, WMAX}, 1'b1, '{WMIN, WMAX, 1'b1, 1'b0}},
    '{'{FN_ADD, ONE, -ONE, 32'sd5, 32'sd7}, 1'b0, '0},
    '{'{FN_MUL, ONE, ONE, ONE, -ONE}, 1'b0, '0},
    '{'{FN_MUL, WMAX, WMAX, WMAX, WMIN}, 1'b0, '0},
    '{'{FN_MUL, WMIN, WMIN, WMIN, WMIN}, 1'b0, '0},
    '{'{FN_MUL, -32'sd1, 32'sd3, 32'sd1, -32'sd1}, 1'b0, '0},
    '{'{FN_CONJ, WMAX, WMIN, 32'sd0, 32'sd0}, 1'b1, '{WMAX, WMAX, 1'b1, 1'b0}},
    '{'{FN_CONJ, WMIN, WMAX, ONE, ONE}, 1'b1, '{WMIN, -WMAX, 1'b0, 1'b0}},
    '{'{FN_MAG, 3 * ONE, 4 * ONE, 32'sd9, 32'sd9}, 1'b1, '{5 * ONE, 32'sd0, 1'b0, 1'b0}},
    '{'{FN_MAG, WMIN, WMIN, 32'sd0, 32'sd0}, 1'b1, '{WMAX, 32'sd0, 1'b1, 1'b0}},
    '{'{FN_MAG, 32'sd0, 32'sd0, WMAX, WMAX}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
    '{'{FN_MAG, -32'sd7, 32'sd2, 32'sd0, 32'sd0}, 1'b0, '0},
    '{'{FN_DIV, WMAX, WMIN, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b1}},
    '{'{FN_DIV, ONE, 32'sd0, 32'sd0, 32'sd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b1}},
    '{'{FN_DIV, 4 * ONE, 2 * ONE, 2 * ONE, 32'sd0}, 1'b1, '{2 * ONE, ONE, 1'b0, 1'b0}},
    '{'{FN_DIV, WMAX, WMAX, 32'sd1, 32'sd0}, 1'b0, '0},
    '{'{FN_DIV, WMIN, WMIN, WMIN, WMIN}, 1'b0, '0},
    '{'{FN_DIV, -ONE, ONE, 32'sd3, -32'sd7}, 1'b0, '0},
    '{'{FN_SPARE5, WMAX, WMIN, WMAX, WMIN}, 1'b1, '0},
    '{'{FN_SPARE6, WMIN, WMAX, ONE, ONE}, 1'b1, '0},
    '{'{FN_SPARE7, -32'sd1, -32'sd1, -32'sd1, -32'sd1}, 1'b1, '0}
  };

  initial begin
    cau_in_t op;
    start      = 1'b0;
    req_i      = '0;
    row_typed  = 1'b0;
    row_expect = '0;
    mismatches = 0;
    beats_seen = 0;
    foreach (ops_done[k]) ops_done[k] = 0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k]) begin
      maybe_idle(1'b1);
      offer_beat(directed[k].op, directed[k].typed, directed[k].want);
    end
    row_typed = 1'b0;

    for (int n = 0; n < N_RANDOM; n++) begin
      // Hold off once until the unit has returned every outstanding beat.
      if (n == 400) begin
        start = 1'b0;
        while (expected_beats.size() != 0) @(negedge clk_i);
      end
      // Items 700 to 999 go back to back to keep the pipelines full.
      maybe_idle(n < 700 || n >= 1000);
      op.func = pick_func();
      op.a_re = pick_operand();
      op.a_im = pick_operand();
      op.b_re = pick_operand();
      op.b_im = pick_operand();
      if (op.func == FN_DIV && $urandom_range(15) == 0) begin
        op.b_re = '0;
        op.b_im = '0;
      end
      offer_beat(op, 1'b0, '0);
    end
    start = 1'b0;

    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("Covered %0d beats: add %0d, mul %0d, conj %0d, mag %0d, div %0d, spare codes %0d.",
             beats_seen, ops_done[FN_ADD], ops_done[FN_MUL], ops_done[FN_CONJ],
             ops_done[FN_MAG], ops_done[FN_DIV],
             ops_done[FN_SPARE5] + ops_done[FN_SPARE6] + ops_done[FN_SPARE7]);
    $display("Mismatching beats: %0d.", mismatches);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost beat.
  initial begin
    #2000000;
    $display("Timeout with %0d beats still outstanding.", expected_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
